// ----- src/rbdc_pkg.sv -----
`timescale 1ns / 1ps
package rbdc_pkg;

  localparam int unsigned DW = 32;

  localparam logic [DW-1:0] SPREAD_BYTE_LIMIT = 32'd255;
  localparam logic [DW-1:0] SPREAD_HALF_LIMIT = 32'd65535;

  localparam logic [2:0] HDR_BYTES = 3'd5;

  localparam logic [1:0] WSEL_BYTE = 2'd0;
  localparam logic [1:0] WSEL_HALF = 2'd1;
  localparam logic [1:0] WSEL_FULL = 2'd2;

  localparam logic [1:0] REG_TAG_BYTE = 2'd0;
  localparam logic [1:0] REG_TAG_HALF = 2'd1;
  localparam logic [1:0] REG_TAG_FULL = 2'd2;

  typedef struct packed {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic          sub;
  } alu_req_t;

  typedef struct packed {
    logic [DW-1:0] res;
    logic          carry;
  } alu_rsp_t;

endpackage

// ----- src/rbdc_alu.sv -----
`timescale 1ns / 1ps
module rbdc_alu
  import rbdc_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [DW:0]   sum;
  logic [DW-1:0] b_op;

  // On a subtraction the carry out is high when a is not below b.
  assign b_op = req.sub ? ~req.b : req.b;
  assign sum = {1'b0, req.a} + {1'b0, b_op} + {{DW{1'b0}}, req.sub};
  assign rsp.res = sum[DW-1:0];
  assign rsp.carry = sum[DW];

endmodule

// ----- src/row_base_delta_compressor.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Signals                      Contents
// in       slave      in_tvalid/tready/tdata/...   one row element per transaction
// out      master     out_tvalid/tready/tdata/...  row header, then one delta per stored element
// cfg      write      cfg_we/cfg_index/cfg_wdata   encoding tags
//
// A non-last element stays in S_IDLE when it is the first of its row or is dropped,
// otherwise it also passes S_MIN and S_MAX, as min and max share one adder-subtractor.
// A last element then passes S_SPREAD for the spread, S_HDR for the header, S_RD and
// S_DLT per stored element (memory read, then delta through the shared unit) and S_OFS for the offset.
// Output back-pressure stalls the sequencer; reset is synchronous and active low.
module row_base_delta_compressor
  import rbdc_pkg::*;
#(
  parameter int ROW_MAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value
  input  logic        in_tlast,   // row_last
  input  logic        in_tuser,   // matrix_first
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // payload, byte_count, row_offset, zero fill
  output logic        out_tlast,  // last
  output logic [9:0]  out_tuser,  // is_header, tag, row_overflow
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int CW = $clog2(ROW_MAX + 1);
  localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MIN    = 3'd1;
  localparam logic [2:0] S_MAX    = 3'd2;
  localparam logic [2:0] S_SPREAD = 3'd3;
  localparam logic [2:0] S_HDR    = 3'd4;
  localparam logic [2:0] S_RD     = 3'd5;
  localparam logic [2:0] S_DLT    = 3'd6;
  localparam logic [2:0] S_OFS    = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          ovf_r, ovf_nxt;
  logic          last_r, last_nxt;
  logic [DW-1:0] min_r, min_nxt;
  logic [DW-1:0] max_r, max_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [DW-1:0] ofs_r, ofs_nxt;
  logic [1:0]    wsel_r, wsel_nxt;
  logic [7:0]    tag_byte_r, tag_half_r, tag_full_r;
  logic [DW-1:0] rd_r;

  logic          o_valid_r, o_valid_nxt;
  logic          o_hdr_r, o_hdr_nxt;
  logic [7:0]    o_tag_r, o_tag_nxt;
  logic [DW-1:0] o_pay_r, o_pay_nxt;
  logic [2:0]    o_bc_r, o_bc_nxt;
  logic [DW-1:0] o_ofs_r, o_ofs_nxt;
  logic          o_ovf_r, o_ovf_nxt;
  logic          o_last_r, o_last_nxt;

  logic [DW-1:0] mem [ROW_MAX];

  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;

  logic          in_acc;
  logic          out_free;
  logic          store_ok;
  logic [7:0]    row_tag;
  logic [DW-1:0] delta_mask;
  logic [CW-1:0] idx_inc;
  logic [8:0]    row_bytes;

  rbdc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_free = !o_valid_r || out_tready;
  assign store_ok = (cnt_r < CW'(ROW_MAX));
  assign idx_inc = idx_r + 1'b1;
  assign row_bytes = 9'(HDR_BYTES) + (9'(cnt_r) << wsel_r);

  always_comb begin
    case (wsel_r)
      WSEL_BYTE: begin
        row_tag = tag_byte_r;
        delta_mask = 32'h0000_00FF;
      end
      WSEL_HALF: begin
        row_tag = tag_half_r;
        delta_mask = 32'h0000_FFFF;
      end
      default: begin
        row_tag = tag_full_r;
        delta_mask = 32'hFFFF_FFFF;
      end
    endcase
  end

  always_comb begin
    alu_req.a = min_r;
    alu_req.b = max_r;
    alu_req.sub = 1'b1;
    case (state_r)
      S_MIN: begin
        alu_req.a = val_r;
        alu_req.b = min_r;
      end
      S_MAX: begin
        alu_req.a = max_r;
        alu_req.b = val_r;
      end
      S_SPREAD: begin
        alu_req.a = max_r;
        alu_req.b = min_r;
      end
      S_DLT: begin
        alu_req.a = rd_r;
        alu_req.b = min_r;
      end
      S_OFS: begin
        alu_req.a = ofs_r;
        alu_req.b = DW'(row_bytes);
        alu_req.sub = 1'b0;
      end
      default: begin
        alu_req.a = min_r;
        alu_req.b = max_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    ovf_nxt = ovf_r;
    last_nxt = last_r;
    min_nxt = min_r;
    max_nxt = max_r;
    val_nxt = val_r;
    ofs_nxt = ofs_r;
    wsel_nxt = wsel_r;
    o_valid_nxt = o_valid_r && !out_tready;
    o_hdr_nxt = o_hdr_r;
    o_tag_nxt = o_tag_r;
    o_pay_nxt = o_pay_r;
    o_bc_nxt = o_bc_r;
    o_ofs_nxt = o_ofs_r;
    o_ovf_nxt = o_ovf_r;
    o_last_nxt = o_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt = in_tdata;
          last_nxt = in_tlast;
          if ((cnt_r == '0) && !ovf_r && in_tuser) begin
            ofs_nxt = '0;
          end
          state_nxt = in_tlast ? S_SPREAD : S_IDLE;
          if (store_ok) begin
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == '0) begin
              min_nxt = in_tdata;
              max_nxt = in_tdata;
            end else begin
              state_nxt = S_MIN;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_MIN: begin
        if (!alu_rsp.carry) begin
          min_nxt = val_r;
        end
        state_nxt = S_MAX;
      end
      S_MAX: begin
        if (!alu_rsp.carry) begin
          max_nxt = val_r;
        end
        state_nxt = last_r ? S_SPREAD : S_IDLE;
      end
      S_SPREAD: begin
        if (alu_rsp.res < SPREAD_BYTE_LIMIT) begin
          wsel_nxt = WSEL_BYTE;
        end else if (alu_rsp.res < SPREAD_HALF_LIMIT) begin
          wsel_nxt = WSEL_HALF;
        end else begin
          wsel_nxt = WSEL_FULL;
        end
        state_nxt = S_HDR;
      end
      S_HDR: begin
        if (out_free) begin
          o_valid_nxt = 1'b1;
          o_hdr_nxt = 1'b1;
          o_tag_nxt = row_tag;
          o_pay_nxt = min_r;
          o_bc_nxt = HDR_BYTES;
          o_ofs_nxt = ofs_r;
          o_ovf_nxt = ovf_r;
          o_last_nxt = (cnt_r == '0);
          idx_nxt = '0;
          state_nxt = (cnt_r == '0) ? S_OFS : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_DLT;
      end
      S_DLT: begin
        if (out_free) begin
          o_valid_nxt = 1'b1;
          o_hdr_nxt = 1'b0;
          o_tag_nxt = row_tag;
          o_pay_nxt = alu_rsp.res & delta_mask;
          o_bc_nxt = 3'(3'd1 << wsel_r);
          o_ofs_nxt = ofs_r;
          o_ovf_nxt = ovf_r;
          o_last_nxt = (idx_inc == cnt_r);
          idx_nxt = idx_inc;
          state_nxt = (idx_inc == cnt_r) ? S_OFS : S_RD;
        end
      end
      S_OFS: begin
        ofs_nxt = alu_rsp.res;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
        min_nxt = '0;
        max_nxt = '0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      ovf_r <= 1'b0;
      last_r <= 1'b0;
      min_r <= '0;
      max_r <= '0;
      ofs_r <= '0;
      wsel_r <= WSEL_BYTE;
      o_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      ovf_r <= ovf_nxt;
      last_r <= last_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
      ofs_r <= ofs_nxt;
      wsel_r <= wsel_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    o_hdr_r <= o_hdr_nxt;
    o_tag_r <= o_tag_nxt;
    o_pay_r <= o_pay_nxt;
    o_bc_r <= o_bc_nxt;
    o_ofs_r <= o_ofs_nxt;
    o_ovf_r <= o_ovf_nxt;
    o_last_r <= o_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_byte_r <= 8'd0;
      tag_half_r <= 8'd1;
      tag_full_r <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAG_BYTE: tag_byte_r <= cfg_wdata;
        REG_TAG_HALF: tag_half_r <= cfg_wdata;
        REG_TAG_FULL: tag_full_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      mem[cnt_r[AW-1:0]] <= in_tdata;
    end
    if (state_r == S_RD) begin
      rd_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata = {5'b0, o_ofs_r, o_bc_r, o_pay_r};
  assign out_tlast = o_last_r;
  assign out_tuser = {o_ovf_r, o_tag_r, o_hdr_r};

endmodule

// ----- src/rbdc_checker.sv -----
`timescale 1ns / 1ps
module rbdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast,
  input logic [9:0]  out_tuser
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A header always occupies five bytes.
  a_hdr_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[34:32] == 3'd5)
    else $error("header byte count wrong");

  // A delta occupies one, two or four bytes.
  a_delta_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata[34:32] == 3'd1 || out_tdata[34:32] == 3'd2 || out_tdata[34:32] == 3'd4)
    else $error("delta byte count wrong");

  // Every row stores at least one element, so the header is never the last result.
  a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tlast)
    else $error("header marked last");

  // The last element of a row starts the emission, so no element is taken next.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted during row emission");

endmodule

bind row_base_delta_compressor rbdc_checker u_rbdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- bench/delta_stream_checker.sv -----
`timescale 1ns / 1ps
module delta_stream_checker
  import rbdc_pkg::*;
#(
  parameter int ROW_MAX = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [31:0]       in_tdata,   // value
  input  logic              in_tlast,   // row_last
  input  logic              in_tuser,   // matrix_first
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [71:0]       out_tdata,  // payload, byte_count, row_offset, zero fill
  input  logic              out_tlast,  // last
  input  logic [9:0]        out_tuser,  // is_header, tag, row_overflow
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  output int unsigned       pending,
  output int unsigned       errors
);

  localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

  typedef struct packed {
    logic        is_header;
    logic [7:0]  tag;
    logic [31:0] payload;
    logic [2:0]  nbytes;
    logic [31:0] offset;
    logic        ovf;
    logic        last;
  } row_word_t;

  logic [7:0]  tag_byte, tag_half, tag_full;
  logic [31:0] row_mem [ROW_MAX];
  logic [31:0] row_min, row_max;
  logic [5:0]  elem_count;
  logic        row_ovf;
  logic [31:0] stream_pos;
  row_word_t   predicted_words[$];
  int unsigned mismatches = 0;

  task automatic compress_element(input logic [31:0] v, input logic lst, input logic fst);
    logic [31:0] spread, mask, offs;
    logic [7:0]  tag;
    logic [2:0]  nbytes;
    row_word_t   w;
    if (elem_count == 0 && !row_ovf && fst) stream_pos = '0;
    if (elem_count < ROW_MAX) begin
      row_mem[elem_count[AW-1:0]] = v;
      if (elem_count == 0) begin
        row_min = v;
        row_max = v;
      end else begin
        if (v < row_min) row_min = v;
        if (v > row_max) row_max = v;
      end
      elem_count++;
    end else begin
      row_ovf = 1'b1;
    end
    if (!lst) return;

    spread = row_max - row_min;
    if (spread < SPREAD_BYTE_LIMIT) begin
      tag = tag_byte; mask = 32'h0000_00FF; nbytes = 3'd1;
    end else if (spread < SPREAD_HALF_LIMIT) begin
      tag = tag_half; mask = 32'h0000_FFFF; nbytes = 3'd2;
    end else begin
      tag = tag_full; mask = 32'hFFFF_FFFF; nbytes = 3'd4;
    end

    offs = stream_pos;
    w = '{is_header: 1'b1, tag: tag, payload: row_min, nbytes: HDR_BYTES,
          offset: offs, ovf: row_ovf, last: (elem_count == 0)};
    predicted_words.push_back(w);
    for (int i = 0; i < elem_count; i++) begin
      w = '{is_header: 1'b0, tag: tag, payload: (row_mem[AW'(i)] - row_min) & mask,
            nbytes: nbytes, offset: offs, ovf: row_ovf, last: (i + 1 == elem_count)};
      predicted_words.push_back(w);
    end

    stream_pos = offs + 32'(HDR_BYTES) + 32'(elem_count) * 32'(nbytes);
    elem_count = '0;
    row_ovf    = 1'b0;
    row_min    = '0;
    row_max    = '0;
  endtask

  always @(posedge clk) begin
    row_word_t got, want;
    if (!rst_n) begin
      tag_byte   = 8'd0;
      tag_half   = 8'd1;
      tag_full   = 8'd2;
      row_min    = '0;
      row_max    = '0;
      elem_count = '0;
      row_ovf    = 1'b0;
      stream_pos = '0;
      predicted_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TAG_BYTE: tag_byte = cfg_wdata;
          REG_TAG_HALF: tag_half = cfg_wdata;
          REG_TAG_FULL: tag_full = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) compress_element(in_tdata, in_tlast, in_tuser);
      if (out_tvalid && out_tready) begin
        got.is_header = out_tuser[0];
        got.tag       = out_tuser[8:1];
        got.ovf       = out_tuser[9];
        got.payload   = out_tdata[31:0];
        got.nbytes    = out_tdata[34:32];
        got.offset    = out_tdata[66:35];
        got.last      = out_tlast;
        if (predicted_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result transaction tdata=%h tuser=%h tlast=%b",
                     $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = predicted_words.pop_front();
          if (got.is_header !== want.is_header || got.tag !== want.tag ||
              got.payload !== want.payload || got.nbytes !== want.nbytes ||
              got.offset !== want.offset || got.ovf !== want.ovf ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected hdr=%b tag=%h payload=%h bytes=%0d offset=%h ovf=%b last=%b",
                       want.is_header, want.tag, want.payload, want.nbytes,
                       want.offset, want.ovf, want.last);
              $display("  actual   hdr=%b tag=%h payload=%h bytes=%0d offset=%h ovf=%b last=%b",
                       got.is_header, got.tag, got.payload, got.nbytes,
                       got.offset, got.ovf, got.last);
            end
          end
        end
      end
    end
    pending <= predicted_words.size();
    errors  <= mismatches;
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import rbdc_pkg::*;

  localparam int ROW_MAX        = 32;
  localparam int RANDOM_ITEMS   = 500;
  localparam int PHASES         = 4;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // value
  logic        in_tlast;   // row_last
  logic        in_tuser;   // matrix_first
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // payload, byte_count, row_offset, zero fill
  logic        out_tlast;  // last
  logic [9:0]  out_tuser;  // is_header, tag, row_overflow
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          rx_hold = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned pending;
  int unsigned errors;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  row_base_delta_compressor #(.ROW_MAX(ROW_MAX)) dut (.*);

  delta_stream_checker #(.ROW_MAX(ROW_MAX)) checker_i (.*);

  task automatic send_item(input logic [31:0] v, input logic lst, input logic fst);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= lst;
    in_tuser  <= fst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_row();
    int unsigned len, pick;
    logic [31:0] base, span;
    logic        fst;
    pick = $urandom_range(0, 19);
    if (pick < 14) len = $urandom_range(1, 6);
    else if (pick < 18) len = $urandom_range(7, ROW_MAX);
    else len = $urandom_range(ROW_MAX + 1, ROW_MAX + 8);
    case ($urandom_range(0, 2))
      0: span = 32'd255;
      1: span = 32'd65535;
      default: span = 32'hFFFF_FFFF;
    endcase
    base = $urandom;
    tx_idle_en = ($urandom_range(0, 5) != 0);
    rx_idle_en = ($urandom_range(0, 5) != 0);
    for (int i = 0; i < len; i++) begin
      fst = (i == 0) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) == 0);
      send_item(base + $urandom_range(0, span), i == len - 1, fst);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_tags(input logic [7:0] t_byte, input logic [7:0] t_half,
                           input logic [7:0] t_full);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TAG_BYTE;
    cfg_wdata <= t_byte;
    @(posedge clk);
    cfg_index <= REG_TAG_HALF;
    cfg_wdata <= t_half;
    @(posedge clk);
    cfg_index <= REG_TAG_FULL;
    cfg_wdata <= t_full;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // When idling is enabled, the receiver draws a random stall before every transaction, with one long hold on request.
  initial begin
    int unsigned gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      gap = rx_idle_en ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** row_base_delta_compressor: FAILED **");
    $finish;
  end

  initial begin
    int unsigned target;
    bit          paused;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_TAG_BYTE;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run with the reset tags.
    send_item(32'd0, 1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(32'h0000_0000, 1'b1, 1'b0);
    send_item(32'd100, 1'b0, 1'b0);
    send_item(32'd354, 1'b1, 1'b0);
    send_item(32'd100, 1'b0, 1'b0);
    send_item(32'd355, 1'b1, 1'b0);
    send_item(32'd7, 1'b0, 1'b0);
    send_item(32'd65541, 1'b1, 1'b0);
    send_item(32'd7, 1'b0, 1'b0);
    send_item(32'd65542, 1'b1, 1'b0);
    // The matrix restarts here; the flag on the second element must be ignored.
    send_item(32'd5, 1'b0, 1'b1);
    send_item(32'd6, 1'b0, 1'b1);
    send_item(32'd4, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(32'hFFFF_FFFE, 1'b1, 1'b0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_tags(8'd255, 8'd0, 8'd85);
        1: load_tags(8'd0, 8'd255, 8'd170);
        2: load_tags(8'($urandom), 8'($urandom), 8'($urandom));
        default: load_tags(8'd255, 8'd255, 8'd0);
      endcase
      if (p == 1) rx_hold = 1'b1;
      paused = 1'b0;
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        send_random_row();
        if (p == 2 && !paused && items_sent + RANDOM_ITEMS / (2 * PHASES) >= target) begin
          in_tvalid <= 1'b0;
          wait_drained();
          paused = 1'b1;
        end
      end
      settle();
    end

    if (errors == 0 && pending == 0)
      $display("** row_base_delta_compressor: PASSED **");
    else
      $display("** row_base_delta_compressor: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rbdc_pkg.sv
src/rbdc_alu.sv
src/row_base_delta_compressor.sv
src/rbdc_checker.sv
bench/delta_stream_checker.sv
bench/tb_top.sv
